// ===== rtl/fcgi_rp_pkg.sv =====
package fcgi_rp_pkg;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_BODY   = 3'b010,
        PH_PAD    = 3'b100
    } phase_t;

    typedef enum logic [6:0] {
        PP_NLEN      = 7'b0000001,
        PP_NLEN_MORE = 7'b0000010,
        PP_VLEN      = 7'b0000100,
        PP_VLEN_MORE = 7'b0001000,
        PP_NAME      = 7'b0010000,
        PP_VALUE     = 7'b0100000,
        PP_SKIP      = 7'b1000000
    } pair_phase_t;

    localparam logic [2:0] KIND_HEADER = 3'd0;
    localparam logic [2:0] KIND_LENGTH = 3'd1;
    localparam logic [2:0] KIND_NAME   = 3'd2;
    localparam logic [2:0] KIND_VALUE  = 3'd3;
    localparam logic [2:0] KIND_STDIN  = 3'd4;
    localparam logic [2:0] KIND_BEGIN  = 3'd5;
    localparam logic [2:0] KIND_OTHER  = 3'd6;
    localparam logic [2:0] KIND_PAD    = 3'd7;

    localparam logic [3:0] EV_NONE        = 4'd0;
    localparam logic [3:0] EV_BEGIN_OK    = 4'd1;
    localparam logic [3:0] EV_ROLE_REJECT = 4'd2;
    localparam logic [3:0] EV_ABORT       = 4'd3;
    localparam logic [3:0] EV_PARAMS_END  = 4'd4;
    localparam logic [3:0] EV_PARAMS_DONE = 4'd5;
    localparam logic [3:0] EV_STDIN_END   = 4'd6;
    localparam logic [3:0] EV_STDIN_DONE  = 4'd7;
    localparam logic [3:0] EV_UNKNOWN     = 4'd8;
    localparam logic [3:0] EV_VERSION     = 4'd9;
    localparam logic [3:0] EV_MALFORMED   = 4'd10;

    localparam logic [7:0] REC_BEGIN  = 8'd1;
    localparam logic [7:0] REC_ABORT  = 8'd2;
    localparam logic [7:0] REC_PARAMS = 8'd4;
    localparam logic [7:0] REC_STDIN  = 8'd5;

    localparam logic [7:0]  FCGI_VERSION = 8'd1;
    localparam logic [15:0] ROLE_RESP    = 16'd1;
    localparam logic [2:0]  HDR_LAST     = 3'd7;

endpackage

// ===== rtl/fastcgi_record_parser.sv =====
// Channel  | Valid     | Ready     | Payload
// ---------+-----------+-----------+-------------------------------------------
// input    | in_valid  | in_ready  | in_byte
// output   | out_valid | out_ready | data_byte .. record_last (one per word)
//
// One word in, one word out. Parser state and the result register both load
// at the accepting edge; the result is offered from the next cycle.
// Throughput, set by the single output register, is one word per cycle while
// out_ready is high; in_ready is high whenever it is empty or being drained.
// rst_n clears the parser state and the output valid flag asynchronously.
module fastcgi_record_parser
    import fcgi_rp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  data_byte,
    output logic [2:0]  byte_kind,
    output logic [7:0]  record_kind,
    output logic [15:0] request_number,
    output logic [30:0] pair_name_length,
    output logic [30:0] pair_value_length,
    output logic        pair_done,
    output logic [3:0]  record_event,
    output logic        keep_alive,
    output logic        disconnect,
    output logic        halted,
    output logic        record_last
);

    phase_t      phase_reg, phase_next;
    pair_phase_t pair_reg, pair_next;
    logic [2:0]  idx_reg, idx_next;
    logic [7:0]  hdr_reg [8];
    logic [7:0]  hdr_next [8];
    logic [15:0] body_reg, body_next;
    logic [7:0]  pad_reg, pad_next;
    logic [30:0] acc_reg, acc_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [30:0] nlen_reg, nlen_next;
    logic [30:0] vlen_reg, vlen_next;
    logic [30:0] field_reg, field_next;
    logic [15:0] role_reg, role_next;
    logic        keep_reg, keep_next;
    logic        disc_reg, disc_next;
    logic        halt_reg, halt_next;

    logic        out_valid_reg;
    logic [7:0]  data_reg;
    logic [2:0]  kind_reg;
    logic [7:0]  rkind_reg;
    logic [15:0] reqnum_reg;
    logic [30:0] onlen_reg, ovlen_reg;
    logic        done_reg;
    logic [3:0]  event_reg;
    logic        okeep_reg, odisc_reg, ohalt_reg, last_reg;

    logic [2:0]  kind;
    logic [3:0]  event_code;
    logic        done, last, show_pair, finish, lengths_ready;
    logic [15:0] hdr_len, cur_len, offset, rem;
    logic [31:0] pair_sum;
    logic [7:0]  rtype;
    logic        accept;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign hdr_len  = {hdr_reg[4], hdr_reg[5]};
    assign offset   = hdr_len - body_reg;
    assign rem      = (body_reg != 16'd0) ? body_reg - 16'd1 : 16'd0;

    always_comb
    begin
        phase_next    = phase_reg;
        pair_next     = pair_reg;
        idx_next      = idx_reg;
        hdr_next      = hdr_reg;
        body_next     = body_reg;
        pad_next      = pad_reg;
        acc_next      = acc_reg;
        cnt_next      = cnt_reg;
        nlen_next     = nlen_reg;
        vlen_next     = vlen_reg;
        field_next    = field_reg;
        role_next     = role_reg;
        keep_next     = keep_reg;
        disc_next     = disc_reg;
        halt_next     = halt_reg;
        kind          = KIND_HEADER;
        event_code    = EV_NONE;
        done          = 1'b0;
        last          = 1'b0;
        show_pair     = 1'b0;
        finish        = 1'b0;
        lengths_ready = 1'b0;
        pair_sum      = 32'd0;
        rtype         = 8'd0;
        cur_len       = 16'd0;

        if (!halt_reg)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    hdr_next[idx_reg] = in_byte;
                    if (idx_reg == HDR_LAST)
                    begin
                        idx_next = 3'd0;
                        if (hdr_reg[0] != FCGI_VERSION)
                        begin
                            event_code = EV_VERSION;
                            halt_next  = 1'b1;
                        end
                        else
                        begin
                            body_next  = hdr_len;
                            pad_next   = hdr_reg[6];
                            role_next  = 16'd0;
                            pair_next  = PP_NLEN;
                            acc_next   = 31'd0;
                            cnt_next   = 2'd0;
                            nlen_next  = 31'd0;
                            vlen_next  = 31'd0;
                            field_next = 31'd0;
                            if (hdr_len != 16'd0)
                                phase_next = PH_BODY;
                            else if (hdr_reg[6] != 8'd0)
                                phase_next = PH_PAD;
                            else
                            begin
                                last   = 1'b1;
                                finish = 1'b1;
                            end
                        end
                    end
                    else
                        idx_next = idx_reg + 3'd1;
                end
                PH_BODY:
                begin
                    case (hdr_reg[1])
                        REC_BEGIN:
                        begin
                            kind = KIND_BEGIN;
                            if (offset == 16'd0)
                                role_next = {in_byte, role_reg[7:0]};
                            else if (offset == 16'd1)
                                role_next = {role_reg[15:8], in_byte};
                            else if (offset == 16'd2)
                                keep_next = in_byte[0];
                        end
                        REC_PARAMS:
                        begin
                            kind = KIND_LENGTH;
                            case (pair_reg)
                                PP_NLEN:
                                begin
                                    nlen_next = 31'd0;
                                    vlen_next = 31'd0;
                                    if (in_byte[7])
                                    begin
                                        acc_next = {24'd0, in_byte[6:0]};
                                        cnt_next = 2'd3;
                                        if (rem < 16'd4)
                                        begin
                                            event_code = EV_MALFORMED;
                                            pair_next  = PP_SKIP;
                                        end
                                        else
                                            pair_next = PP_NLEN_MORE;
                                    end
                                    else
                                    begin
                                        nlen_next = {23'd0, in_byte};
                                        if (rem < 16'd1)
                                        begin
                                            event_code = EV_MALFORMED;
                                            pair_next  = PP_SKIP;
                                        end
                                        else
                                            pair_next = PP_VLEN;
                                    end
                                end
                                PP_NLEN_MORE:
                                begin
                                    acc_next = {acc_reg[22:0], in_byte};
                                    cnt_next = cnt_reg - 2'd1;
                                    if (cnt_next == 2'd0)
                                    begin
                                        nlen_next = acc_next;
                                        pair_next = PP_VLEN;
                                    end
                                end
                                PP_VLEN:
                                begin
                                    if (in_byte[7])
                                    begin
                                        acc_next = {24'd0, in_byte[6:0]};
                                        cnt_next = 2'd3;
                                        if (rem < 16'd3)
                                        begin
                                            event_code = EV_MALFORMED;
                                            pair_next  = PP_SKIP;
                                        end
                                        else
                                            pair_next = PP_VLEN_MORE;
                                    end
                                    else
                                    begin
                                        vlen_next     = {23'd0, in_byte};
                                        lengths_ready = 1'b1;
                                    end
                                end
                                PP_VLEN_MORE:
                                begin
                                    acc_next = {acc_reg[22:0], in_byte};
                                    cnt_next = cnt_reg - 2'd1;
                                    if (cnt_next == 2'd0)
                                    begin
                                        vlen_next     = acc_next;
                                        lengths_ready = 1'b1;
                                    end
                                end
                                PP_NAME:
                                begin
                                    kind = KIND_NAME;
                                    if (field_reg != 31'd0)
                                        field_next = field_reg - 31'd1;
                                    if (field_next == 31'd0)
                                    begin
                                        if (vlen_reg != 31'd0)
                                        begin
                                            field_next = vlen_reg;
                                            pair_next  = PP_VALUE;
                                        end
                                        else
                                        begin
                                            done      = 1'b1;
                                            pair_next = PP_NLEN;
                                        end
                                    end
                                end
                                PP_VALUE:
                                begin
                                    kind = KIND_VALUE;
                                    if (field_reg != 31'd0)
                                        field_next = field_reg - 31'd1;
                                    if (field_next == 31'd0)
                                    begin
                                        done      = 1'b1;
                                        pair_next = PP_NLEN;
                                    end
                                end
                                default:
                                    kind = KIND_OTHER;
                            endcase
                            if (lengths_ready)
                            begin
                                pair_sum = {1'b0, nlen_next} + {1'b0, vlen_next};
                                if (pair_sum > {16'd0, rem})
                                begin
                                    event_code = EV_MALFORMED;
                                    pair_next  = PP_SKIP;
                                end
                                else if (nlen_next != 31'd0)
                                begin
                                    field_next = nlen_next;
                                    pair_next  = PP_NAME;
                                end
                                else if (vlen_next != 31'd0)
                                begin
                                    field_next = vlen_next;
                                    pair_next  = PP_VALUE;
                                end
                                else
                                begin
                                    done      = 1'b1;
                                    pair_next = PP_NLEN;
                                end
                            end
                            show_pair = (kind == KIND_LENGTH) || (kind == KIND_NAME)
                                        || (kind == KIND_VALUE);
                        end
                        REC_STDIN:
                            kind = KIND_STDIN;
                        default:
                            kind = KIND_OTHER;
                    endcase
                    body_next = rem;
                    if (rem == 16'd0)
                    begin
                        if (pad_reg != 8'd0)
                            phase_next = PH_PAD;
                        else
                        begin
                            last   = 1'b1;
                            finish = 1'b1;
                        end
                    end
                end
                PH_PAD:
                begin
                    kind = KIND_PAD;
                    if (pad_reg != 8'd0)
                        pad_next = pad_reg - 8'd1;
                    if (pad_next == 8'd0)
                    begin
                        last   = 1'b1;
                        finish = 1'b1;
                    end
                end
                default:
                    phase_next = PH_HEADER;
            endcase

            if (finish)
            begin
                phase_next = PH_HEADER;
                rtype      = hdr_next[1];
                cur_len    = {hdr_next[4], hdr_next[5]};
                case (rtype)
                    REC_BEGIN:
                    begin
                        if (event_code == EV_NONE)
                            event_code = (role_next == ROLE_RESP) ? EV_BEGIN_OK
                                                                  : EV_ROLE_REJECT;
                        if (role_next != ROLE_RESP)
                            halt_next = 1'b1;
                    end
                    REC_ABORT:
                    begin
                        if (event_code == EV_NONE)
                            event_code = EV_ABORT;
                        if (!keep_next)
                        begin
                            disc_next = 1'b1;
                            halt_next = 1'b1;
                        end
                    end
                    REC_PARAMS:
                    begin
                        if (event_code == EV_NONE)
                            event_code = (cur_len == 16'd0) ? EV_PARAMS_END
                                                            : EV_PARAMS_DONE;
                    end
                    REC_STDIN:
                    begin
                        if (event_code == EV_NONE)
                            event_code = (cur_len == 16'd0) ? EV_STDIN_END
                                                            : EV_STDIN_DONE;
                        if (cur_len == 16'd0 && !keep_next)
                        begin
                            disc_next = 1'b1;
                            halt_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (event_code == EV_NONE)
                            event_code = EV_UNKNOWN;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            pair_reg      <= PP_NLEN;
            idx_reg       <= 3'd0;
            hdr_reg       <= '{default: 8'd0};
            body_reg      <= 16'd0;
            pad_reg       <= 8'd0;
            acc_reg       <= 31'd0;
            cnt_reg       <= 2'd0;
            nlen_reg      <= 31'd0;
            vlen_reg      <= 31'd0;
            field_reg     <= 31'd0;
            role_reg      <= 16'd0;
            keep_reg      <= 1'b0;
            disc_reg      <= 1'b0;
            halt_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                pair_reg  <= pair_next;
                idx_reg   <= idx_next;
                hdr_reg   <= hdr_next;
                body_reg  <= body_next;
                pad_reg   <= pad_next;
                acc_reg   <= acc_next;
                cnt_reg   <= cnt_next;
                nlen_reg  <= nlen_next;
                vlen_reg  <= vlen_next;
                field_reg <= field_next;
                role_reg  <= role_next;
                keep_reg  <= keep_next;
                disc_reg  <= disc_next;
                halt_reg  <= halt_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg   <= in_byte;
            kind_reg   <= kind;
            rkind_reg  <= hdr_next[1];
            reqnum_reg <= {hdr_next[2], hdr_next[3]};
            onlen_reg  <= show_pair ? nlen_next : 31'd0;
            ovlen_reg  <= show_pair ? vlen_next : 31'd0;
            done_reg   <= done;
            event_reg  <= event_code;
            okeep_reg  <= keep_next;
            odisc_reg  <= disc_next;
            ohalt_reg  <= halt_next;
            last_reg   <= last;
        end
    end

    assign out_valid         = out_valid_reg;
    assign data_byte         = data_reg;
    assign byte_kind         = kind_reg;
    assign record_kind       = rkind_reg;
    assign request_number    = reqnum_reg;
    assign pair_name_length  = onlen_reg;
    assign pair_value_length = ovlen_reg;
    assign pair_done         = done_reg;
    assign record_event      = event_reg;
    assign keep_alive        = okeep_reg;
    assign disconnect        = odisc_reg;
    assign halted            = ohalt_reg;
    assign record_last       = last_reg;

endmodule
